### rtl/ist_pkg.sv
package ist_pkg;

   localparam int unsigned MAX_IMAGE_PIXELS_DEF = 1048576;
   localparam int unsigned MAX_IMAGES_DEF = 1024;

   localparam int PIXEL_W = 8;
   localparam int GAIN_W = 10;
   localparam int GAIN_FRAC = 8;
   localparam int LIMIT_W = 11;
   localparam int PROD_W = PIXEL_W + GAIN_W;
   localparam int QUEUE_DEPTH = 4;
   localparam longint unsigned PIXEL_MAX = 255;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_AVG,
      BK_MEAN,
      BK_PMEAN,
      BK_EMIT
   } back_state_type;

   function automatic int sum_width(input int unsigned max_pixels);
      longint unsigned cap;
      cap = PIXEL_MAX * max_pixels;
      return $clog2(cap + 1);
   endfunction

   function automatic int count_width(input int unsigned max_pixels);
      longint unsigned cap;
      cap = longint'(max_pixels) + 1;
      return $clog2(cap + 1);
   endfunction

   function automatic int total_width(input int unsigned max_images);
      longint unsigned cap;
      cap = PIXEL_MAX * max_images;
      return $clog2(cap + 1);
   endfunction

   function automatic int seen_width(input int unsigned max_images);
      longint unsigned cap;
      cap = longint'(max_images);
      return $clog2(cap + 1);
   endfunction

   function automatic int max_of(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

### rtl/ist_if.sv
interface ist_req_if import ist_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PIXEL_W-1:0]   pixel;
   logic                 image_end;
   logic                 set_end;

   modport source (output valid, output pixel, output image_end, output set_end,
                   input ready);
   modport sink (input valid, input pixel, input image_end, input set_end,
                 output ready);
endinterface

interface ist_rsp_if import ist_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [LIMIT_W-1:0]   limit;
   logic                 empty_set;

   modport source (output valid, output limit, output empty_set, input ready);
   modport sink (input valid, input limit, input empty_set, output ready);
endinterface

### rtl/ist_front.sv
module ist_front import ist_pkg::*; #(
   parameter int unsigned MAX_IMAGE_PIXELS = MAX_IMAGE_PIXELS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   ist_req_if.sink                                 req_bus,
   input  logic                                    full,
   output logic                                    push,
   output logic [sum_width(MAX_IMAGE_PIXELS)-1:0]  push_sum,
   output logic [count_width(MAX_IMAGE_PIXELS)-1:0] push_count,
   output logic [PIXEL_W-1:0]                      push_peak,
   output logic                                    push_set_end
);
   localparam int SUM_W = sum_width(MAX_IMAGE_PIXELS);
   localparam int CNT_W = count_width(MAX_IMAGE_PIXELS);
   localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(PIXEL_MAX * MAX_IMAGE_PIXELS);
   localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(longint'(MAX_IMAGE_PIXELS) + 1);

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PIXEL_W-1:0] peak_ff, peak_in;
   logic [SUM_W:0]     sum_add;
   logic [SUM_W-1:0]   sum_upd;
   logic [CNT_W-1:0]   count_upd;
   logic [PIXEL_W-1:0] peak_upd;
   logic               accept;
   logic               close;

   assign req_bus.ready = !full;
   assign accept = req_bus.valid && req_bus.ready;
   assign close = req_bus.image_end || req_bus.set_end;

   always_comb begin
      sum_add = {1'b0, sum_ff} + (SUM_W+1)'(req_bus.pixel);
      peak_upd = (req_bus.pixel > peak_ff) ? req_bus.pixel : peak_ff;
      sum_upd = sum_ff;
      count_upd = count_ff;
      if (req_bus.pixel != '0) begin
         sum_upd = (sum_add > (SUM_W+1)'(SUM_CAP)) ? SUM_CAP : sum_add[SUM_W-1:0];
         if (count_ff < CNT_CAP) begin
            count_upd = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      sum_in = sum_ff;
      count_in = count_ff;
      peak_in = peak_ff;
      if (accept) begin
         if (close) begin
            sum_in = '0;
            count_in = CNT_W'(1);
            peak_in = '0;
         end else begin
            sum_in = sum_upd;
            count_in = count_upd;
            peak_in = peak_upd;
         end
      end
   end

   assign push = accept && close;
   assign push_sum = sum_upd;
   assign push_count = count_upd;
   assign push_peak = peak_upd;
   assign push_set_end = req_bus.set_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         count_ff <= CNT_W'(1);
         peak_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         count_ff <= count_in;
         peak_ff <= peak_in;
      end
   end

endmodule

### rtl/ist_queue.sv
module ist_queue import ist_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push;
   logic              do_pop;

   assign full = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/ist_div.sv
module ist_div import ist_pkg::*; #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    rem_shift;
   logic              fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      fits = (rem_shift >= {1'b0, den_ff});
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = num;
         rem_in = '0;
         den_in = den;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DEN_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quo = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

### rtl/ist_back.sv
module ist_back import ist_pkg::*; #(
   parameter int unsigned MAX_IMAGE_PIXELS = MAX_IMAGE_PIXELS_DEF,
   parameter int unsigned MAX_IMAGES = MAX_IMAGES_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     q_valid,
   output logic                                     q_pop,
   input  logic [sum_width(MAX_IMAGE_PIXELS)-1:0]   q_sum,
   input  logic [count_width(MAX_IMAGE_PIXELS)-1:0] q_count,
   input  logic [PIXEL_W-1:0]                       q_peak,
   input  logic                                     q_set_end,
   input  logic [GAIN_W-1:0]                        blend_gain,
   ist_rsp_if.source                                rsp_bus
);
   localparam int SUM_W = sum_width(MAX_IMAGE_PIXELS);
   localparam int CNT_W = count_width(MAX_IMAGE_PIXELS);
   localparam int TOT_W = total_width(MAX_IMAGES);
   localparam int SEEN_W = seen_width(MAX_IMAGES);
   localparam int NUM_W = max_of(SUM_W, TOT_W);
   localparam int DEN_W = max_of(CNT_W, SEEN_W);
   localparam logic [SEEN_W-1:0] SEEN_CAP = SEEN_W'(MAX_IMAGES);

   back_state_type      state_ff, state_in;
   logic [TOT_W-1:0]    avg_total_ff, peak_total_ff;
   logic [SEEN_W-1:0]   seen_ff;
   logic [PIXEL_W-1:0]  peak_ff;
   logic                set_end_ff;
   logic [PIXEL_W-1:0]  mean_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                empty_ff;
   logic                rsp_valid_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic                rsp_empty_ff;

   logic [TOT_W-1:0]    avg_total_upd, peak_total_upd;
   logic [SEEN_W-1:0]   seen_upd;
   logic                take;
   logic [PIXEL_W-1:0]  quo_byte;
   logic [PIXEL_W-1:0]  gap;
   logic [PROD_W-1:0]   prod_in;
   logic [LIMIT_W-1:0]  limit_in;
   logic                out_free;

   logic                div_start;
   logic [NUM_W-1:0]    div_num;
   logic [DEN_W-1:0]    div_den;
   logic                div_done;
   logic [NUM_W-1:0]    div_quo;
   logic                acc_load;
   logic                mean_load;
   logic                prod_load;
   logic                emit_load;

   ist_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign quo_byte = div_quo[PIXEL_W-1:0];
   assign take = (seen_ff < SEEN_CAP);
   assign avg_total_upd = take ? avg_total_ff + TOT_W'(quo_byte) : avg_total_ff;
   assign peak_total_upd = take ? peak_total_ff + TOT_W'(peak_ff) : peak_total_ff;
   assign seen_upd = take ? seen_ff + SEEN_W'(1) : seen_ff;
   assign gap = (quo_byte > mean_ff) ? quo_byte - mean_ff : '0;
   assign prod_in = PROD_W'(gap) * PROD_W'(blend_gain);
   assign limit_in = empty_ff ? '0
                     : LIMIT_W'(mean_ff) + LIMIT_W'(prod_ff[PROD_W-1:GAIN_FRAC]);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               state_in = BK_AVG;
            end
         end
         BK_AVG: begin
            if (div_done) begin
               if (!set_end_ff) begin
                  state_in = BK_IDLE;
               end else if (seen_upd == '0) begin
                  state_in = BK_EMIT;
               end else begin
                  state_in = BK_MEAN;
               end
            end
         end
         BK_MEAN: begin
            if (div_done) begin
               state_in = BK_PMEAN;
            end
         end
         BK_PMEAN: begin
            if (div_done) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop = 1'b0;
      div_start = 1'b0;
      div_num = NUM_W'(q_sum);
      div_den = DEN_W'(q_count);
      acc_load = 1'b0;
      mean_load = 1'b0;
      prod_load = 1'b0;
      emit_load = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            q_pop = q_valid;
            div_start = q_valid;
         end
         BK_AVG: begin
            acc_load = div_done;
            div_start = div_done && set_end_ff && (seen_upd != '0);
            div_num = NUM_W'(avg_total_upd);
            div_den = DEN_W'(seen_upd);
         end
         BK_MEAN: begin
            mean_load = div_done;
            div_start = div_done;
            div_num = NUM_W'(peak_total_ff);
            div_den = DEN_W'(seen_ff);
         end
         BK_PMEAN: begin
            prod_load = div_done;
         end
         BK_EMIT: begin
            emit_load = out_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         avg_total_ff <= '0;
         peak_total_ff <= '0;
         seen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (acc_load) begin
            avg_total_ff <= avg_total_upd;
            peak_total_ff <= peak_total_upd;
            seen_ff <= seen_upd;
         end else if (emit_load) begin
            avg_total_ff <= '0;
            peak_total_ff <= '0;
            seen_ff <= '0;
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         peak_ff <= q_peak;
         set_end_ff <= q_set_end;
      end
      if (acc_load) begin
         empty_ff <= (seen_upd == '0);
      end
      if (mean_load) begin
         mean_ff <= quo_byte;
      end
      if (prod_load) begin
         prod_ff <= prod_in;
      end
      if (emit_load) begin
         limit_ff <= limit_in;
         rsp_empty_ff <= empty_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.limit = limit_ff;
   assign rsp_bus.empty_set = rsp_empty_ff;

endmodule

### rtl/image_set_threshold_estimator.sv
// channel   direction  payload                         transfer when
// req_bus   in         pixel[7:0], image_end, set_end  valid && ready
// rsp_bus   out        limit[10:0], empty_set          valid && ready
// csr       in         csr_wdata[9:0] (blend_gain)     csr_we
//
// Pixels transfer one per cycle; ready drops only while the close queue is full.
// Each closed image costs the back end one division in the shared radix-2
// divider of NUM_W bits (NUM_W = 28 at default sizes); a set end adds two more
// divisions, the gain multiply and the output load.
// The four-entry close queue absorbs bursts of short images; a held result stalls
// the back end until rsp_bus.ready. Reset is synchronous, with no clearing pass.
module image_set_threshold_estimator import ist_pkg::*; #(
   parameter int unsigned MAX_IMAGE_PIXELS = MAX_IMAGE_PIXELS_DEF,
   parameter int unsigned MAX_IMAGES = MAX_IMAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   ist_req_if.sink           req_bus,
   ist_rsp_if.source         rsp_bus,
   input  logic              csr_we,
   input  logic [GAIN_W-1:0] csr_wdata
);
   localparam int SUM_W = sum_width(MAX_IMAGE_PIXELS);
   localparam int CNT_W = count_width(MAX_IMAGE_PIXELS);
   localparam int ENT_W = SUM_W + CNT_W + PIXEL_W + 1;

   logic [GAIN_W-1:0]  blend_gain_ff;
   logic               push;
   logic [SUM_W-1:0]   push_sum;
   logic [CNT_W-1:0]   push_count;
   logic [PIXEL_W-1:0] push_peak;
   logic               push_set_end;
   logic               full;
   logic               q_valid;
   logic               q_pop;
   logic [ENT_W-1:0]   q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_gain_ff <= '0;
      end else if (csr_we) begin
         blend_gain_ff <= csr_wdata;
      end
   end

   ist_front #(
      .MAX_IMAGE_PIXELS (MAX_IMAGE_PIXELS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .full         (full),
      .push         (push),
      .push_sum     (push_sum),
      .push_count   (push_count),
      .push_peak    (push_peak),
      .push_set_end (push_set_end)
   );

   ist_queue #(
      .WIDTH (ENT_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_sum, push_count, push_peak, push_set_end}),
      .full      (full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   ist_back #(
      .MAX_IMAGE_PIXELS (MAX_IMAGE_PIXELS),
      .MAX_IMAGES       (MAX_IMAGES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_sum      (q_data[ENT_W-1 -: SUM_W]),
      .q_count    (q_data[CNT_W+PIXEL_W -: CNT_W]),
      .q_peak     (q_data[PIXEL_W:1]),
      .q_set_end  (q_data[0]),
      .blend_gain (blend_gain_ff),
      .rsp_bus    (rsp_bus)
   );

endmodule
